>>> sv/bppf_pkg.sv
// broad-phase pair filter: shared types and constants
// no dependencies
package bppf_pkg;

	localparam int unsigned IdW    = 32;
	localparam int unsigned MaskW  = 64;
	localparam int unsigned CoordW = 32;

	// register indexes on the config port
	localparam logic RegAndMask = 1'b0;
	localparam logic RegOrMask  = 1'b1;

	typedef struct packed {
		logic [IdW-1:0]           id;
		logic [MaskW-1:0]         cat;
		logic [MaskW-1:0]         col;
		logic signed [CoordW-1:0] min_x;
		logic signed [CoordW-1:0] min_y;
		logic signed [CoordW-1:0] min_z;
		logic signed [CoordW-1:0] max_x;
		logic signed [CoordW-1:0] max_y;
		logic signed [CoordW-1:0] max_z;
	} shape_t;

	// word travelling down the result chain
	typedef struct packed {
		logic           hit;
		logic [IdW-1:0] id;
	} scan_t;

	// per-cell controls from the sequencer
	typedef struct packed {
		logic load;
		logic shift;
		logic wr_en;
		logic live;
	} cell_ctl_t;

endpackage

>>> sv/bppf_if.sv
// handshake channels of the pair filter: shape words in, pair words out
// depends on bppf_pkg
interface shape_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 start_new_set;
	logic [bppf_pkg::IdW-1:0]             shape_id;
	logic [bppf_pkg::MaskW-1:0]           category_bits;
	logic [bppf_pkg::MaskW-1:0]           collide_bits;
	logic signed [bppf_pkg::CoordW-1:0]   box_min_x;
	logic signed [bppf_pkg::CoordW-1:0]   box_min_y;
	logic signed [bppf_pkg::CoordW-1:0]   box_min_z;
	logic signed [bppf_pkg::CoordW-1:0]   box_max_x;
	logic signed [bppf_pkg::CoordW-1:0]   box_max_y;
	logic signed [bppf_pkg::CoordW-1:0]   box_max_z;

	modport source (output valid, start_new_set, shape_id, category_bits, collide_bits,
		box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, input ready);
	modport sink (input valid, start_new_set, shape_id, category_bits, collide_bits,
		box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface pair_if;
	logic                     valid;
	logic                     ready;
	logic [bppf_pkg::IdW-1:0] first_id;
	logic [bppf_pkg::IdW-1:0] second_id;
	logic                     set_full;
	logic                     last_of_run;

	modport source (output valid, first_id, second_id, set_full, last_of_run, input ready);
	modport sink (input valid, first_id, second_id, set_full, last_of_run, output ready);
endinterface

>>> sv/bppf_cell.sv
// one storage cell: holds a shape, tests it against the probe, passes scan words on
// depends on bppf_pkg
module bppf_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bppf_pkg::cell_ctl_t          ctl,
	input  bppf_pkg::shape_t             probe,
	input  logic [bppf_pkg::MaskW-1:0]   and_mask,
	input  logic [bppf_pkg::MaskW-1:0]   or_mask,
	input  bppf_pkg::scan_t              scan_in,
	output bppf_pkg::scan_t              scan_out
);

	bppf_pkg::shape_t            shape_q;
	logic                        hit_q;
	logic [bppf_pkg::IdW-1:0]    id_q;
	logic [bppf_pkg::MaskW-1:0]  ab;
	logic [bppf_pkg::MaskW-1:0]  ba;
	logic                        mask_ok;
	logic                        box_ok;

	assign ab = shape_q.cat & probe.col;
	assign ba = probe.cat & shape_q.col;
	assign mask_ok = ((ab & and_mask) != '0) && ((ba & and_mask) != '0)
		&& (((ab | ba) & or_mask) != '0);
	// touching faces count as overlap
	assign box_ok = (shape_q.min_x <= probe.max_x) && (probe.min_x <= shape_q.max_x)
		&& (shape_q.min_y <= probe.max_y) && (probe.min_y <= shape_q.max_y)
		&& (shape_q.min_z <= probe.max_z) && (probe.min_z <= shape_q.max_z);

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			shape_q <= probe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.load) begin
			hit_q <= ctl.live && mask_ok && box_ok;
		end else if (ctl.shift) begin
			hit_q <= scan_in.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			id_q <= shape_q.id;
		end else if (ctl.shift) begin
			id_q <= scan_in.id;
		end
	end

	assign scan_out.hit = hit_q;
	assign scan_out.id  = id_q;

endmodule

>>> sv/broad_phase_pair_filter.sv
// broad-phase pair filter top level: sequencer, config registers, chain of shape cells
// depends on bppf_pkg, bppf_if (shape_if, pair_if) and bppf_cell
//
//  port    | dir | words
//  --------+-----+-----------------------------------------------
//  shape   | in  | one shape per word (id, masks, box)
//  pair    | out | one pair or store-full word per result
//  apb     | in  | and_test_mask at 0x0, or_test_mask at 0x8
//
// a shape is latched, then all cells test it in parallel, then the hit chain shifts
// toward cell 0 one cell a cycle, unless a hit at its head waits on the pair port, until
// no hit is left, and the shape is stored in the next free cell.
// a shape hitting a full store goes through StFull and yields one store-full word.
// reset empties the store and sets both masks to all ones; no clearing pass.
// a stalled pair port freezes the chain on a hit at its head.
module broad_phase_pair_filter #(
	parameter int unsigned MAX_SHAPES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	shape_if.sink         shape,
	pair_if.source        pair,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready
);

	localparam int unsigned CntW = $clog2(MAX_SHAPES + 1);

	localparam logic [2:0] StIdle  = 3'd0;
	localparam logic [2:0] StLoad  = 3'd1;
	localparam logic [2:0] StScan  = 3'd2;
	localparam logic [2:0] StFull  = 3'd3;

	logic [2:0]                     state_q;
	logic [CntW-1:0]                count_q;
	bppf_pkg::shape_t               probe_q;
	logic [bppf_pkg::MaskW-1:0]     and_mask_q;
	logic [bppf_pkg::MaskW-1:0]     or_mask_q;

	// output register
	logic                           out_valid_q;
	logic [bppf_pkg::IdW-1:0]       out_first_q;
	logic [bppf_pkg::IdW-1:0]       out_second_q;
	logic                           out_full_q;
	logic                           out_last_q;

	bppf_pkg::scan_t                chain [MAX_SHAPES+1];
	logic [MAX_SHAPES-1:0]          hits;
	logic                           any_hit;
	logic                           rest_hit;
	logic                           out_free;
	logic                           in_acc;
	logic                           store_en;
	logic                           shift_en;
	logic                           emit_pair;
	logic                           cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[3] == bppf_pkg::RegOrMask) ? or_mask_q : and_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			and_mask_q <= '1;
			or_mask_q  <= '1;
		end else if (cfg_wr) begin
			case (paddr[3])
				bppf_pkg::RegAndMask: and_mask_q <= pwdata;
				bppf_pkg::RegOrMask:  or_mask_q  <= pwdata;
				default: ;
			endcase
		end
	end

	assign shape.ready = (state_q == StIdle);
	assign in_acc      = shape.valid && shape.ready;
	assign out_free    = !out_valid_q || pair.ready;

	// the chain end feeds zeros into the last cell
	assign chain[MAX_SHAPES] = '0;

	always_comb begin
		for (int k = 0; k < MAX_SHAPES; k++) begin
			hits[k] = chain[k].hit;
		end
	end
	assign any_hit   = |hits;
	assign rest_hit  = |(hits >> 1);
	assign emit_pair = (state_q == StScan) && hits[0] && out_free;
	assign shift_en  = (state_q == StScan) && any_hit && (!hits[0] || out_free);
	assign store_en  = (state_q == StScan) && !any_hit;

	for (genvar k = 0; k < MAX_SHAPES; k++) begin : g_cell
		bppf_pkg::cell_ctl_t ctl;
		assign ctl.load  = (state_q == StLoad);
		assign ctl.shift = shift_en;
		assign ctl.wr_en = store_en && (count_q == CntW'(k));
		assign ctl.live  = (count_q > CntW'(k));
		bppf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.probe    (probe_q),
			.and_mask (and_mask_q),
			.or_mask  (or_mask_q),
			.scan_in  (chain[k+1]),
			.scan_out (chain[k])
		);
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			probe_q.id    <= shape.shape_id;
			probe_q.cat   <= shape.category_bits;
			probe_q.col   <= shape.collide_bits;
			probe_q.min_x <= shape.box_min_x;
			probe_q.min_y <= shape.box_min_y;
			probe_q.min_z <= shape.box_min_z;
			probe_q.max_x <= shape.box_max_x;
			probe_q.max_y <= shape.box_max_y;
			probe_q.max_z <= shape.box_max_z;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			count_q <= '0;
		end else begin
			case (state_q)
				StIdle: begin
					if (in_acc) begin
						if (shape.start_new_set) begin
							count_q <= '0;
							state_q <= StLoad;
						end else if (count_q == CntW'(MAX_SHAPES)) begin
							state_q <= StFull;
						end else begin
							state_q <= StLoad;
						end
					end
				end
				StLoad: state_q <= StScan;
				StScan: begin
					if (!any_hit) begin
						count_q <= count_q + 1'b1;
						state_q <= StIdle;
					end
				end
				StFull: begin
					if (out_free) begin
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_pair || (state_q == StFull && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (pair.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_pair) begin
			out_first_q  <= chain[0].id;
			out_second_q <= probe_q.id;
			out_full_q   <= 1'b0;
			out_last_q   <= !rest_hit;
		end else if (state_q == StFull && out_free) begin
			out_first_q  <= '0;
			out_second_q <= probe_q.id;
			out_full_q   <= 1'b1;
			out_last_q   <= 1'b1;
		end
	end

	assign pair.valid       = out_valid_q;
	assign pair.first_id    = out_first_q;
	assign pair.second_id   = out_second_q;
	assign pair.set_full    = out_full_q;
	assign pair.last_of_run = out_last_q;

	// checks
	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		pair.valid && pair.set_full |-> pair.last_of_run && pair.first_id == '0)
		else $error("store-full word malformed");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MAX_SHAPES))
		else $error("shape count beyond capacity");

	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StScan && !any_hit |=> state_q == StIdle
			&& count_q == $past(count_q) + 1'b1)
		else $error("store step missed after scan");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StLoad |=> state_q == StScan && !shape.ready)
		else $error("input taken during scan");

endmodule
